### rtl/rpiq_pkg.sv
// ----------------------------------------------------------------------------
// Ready priority issue queue package
// Shared entry, command, sweep and result types, FSM states and codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rpiq_pkg;

  // One queued instruction
  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] weight;
    logic [3:0]  latency;
    logic [15:0] earliest;
  } entry_t;

  // Item under work, broadcast to every cell
  typedef struct packed {
    logic        deq;
    logic        heur;
    entry_t      item;
    logic [15:0] cur;
  } cmd_t;

  // Search record handed from cell to cell
  typedef struct packed {
    logic        active;
    logic        found;
    logic [7:0]  pick_tag;
    logic [15:0] pick_ec;
    logic [7:0]  low_tag;
    logic [15:0] low_ec;
  } sweep_t;

  // Result fields waiting for the output register
  typedef struct packed {
    logic        valid_res;
    logic [7:0]  out_tag;
    logic [15:0] next_cycle;
    logic        full_error;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_SHIFT,
    ST_DONE
  } state_e;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  localparam logic HEUR_WEIGHT  = 1'b0;
  localparam logic HEUR_LATENCY = 1'b1;

  localparam logic [1:0] REG_HEUR_ADDR = 2'd0;

  localparam logic [15:0] CYCLE_MAX = 16'hFFFF;

endpackage

`default_nettype wire

### rtl/rpiq_cell.sv
// ----------------------------------------------------------------------------
// Ready priority issue queue cell
// Holds one queue slot, takes part in the search sweep and in the shift.
// ----------------------------------------------------------------------------
`default_nettype none

module rpiq_cell #(
  parameter int IDX_W    = 6,
  parameter int CNT_W    = 7,
  parameter int CELL_IDX = 0
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  rpiq_pkg::cmd_t          cmd_i,
  input  wire  [CNT_W-1:0]        count_i,
  input  wire  [IDX_W-1:0]        pos_i,
  input  wire                     shift_i,
  input  rpiq_pkg::entry_t        left_i,
  input  rpiq_pkg::entry_t        right_i,
  output rpiq_pkg::entry_t        entry_o,
  input  rpiq_pkg::sweep_t        sw_i,
  input  wire  [IDX_W-1:0]        pick_i,
  input  wire  [IDX_W-1:0]        low_i,
  output rpiq_pkg::sweep_t        sw_o,
  output logic [IDX_W-1:0]        pick_o,
  output logic [IDX_W-1:0]        low_o
);

  localparam logic [CNT_W-1:0] K_C   = CNT_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] K1_C  = CNT_W'(CELL_IDX + 1);
  localparam logic [IDX_W-1:0] KI_C  = IDX_W'(CELL_IDX);
  localparam bit               FIRST = (CELL_IDX == 0);

  rpiq_pkg::entry_t ent_q, ent_d;
  rpiq_pkg::sweep_t sw_q, sw_d;
  logic [IDX_W-1:0] pick_q, pick_d, low_q, low_d;

  logic             occ;
  logic             ready;
  logic             beats_key;
  logic             beats_head;
  logic [CNT_W-1:0] pos_ext;

  assign occ     = K_C < count_i;
  assign ready   = ent_q.earliest <= cmd_i.cur;
  assign pos_ext = CNT_W'(pos_i);

  // New item ordered ahead of this entry
  always_comb begin
    if (cmd_i.heur == rpiq_pkg::HEUR_LATENCY) begin
      beats_key  = cmd_i.item.latency > ent_q.latency;
      beats_head = cmd_i.item.latency > ent_q.latency;
    end else begin
      beats_key  = cmd_i.item.weight > ent_q.weight;
      beats_head = (cmd_i.item.weight > ent_q.weight) ||
                   ((cmd_i.item.weight == ent_q.weight) &&
                    (cmd_i.item.latency > ent_q.latency));
    end
  end

  // Search step: first ready entry, else lowest earliest; insert position
  always_comb begin
    sw_d   = sw_i;
    pick_d = pick_i;
    low_d  = low_i;
    if (sw_i.active && !sw_i.found) begin
      if (cmd_i.deq == rpiq_pkg::MODE_DEQ) begin
        if (occ) begin
          if (ready) begin
            sw_d.found    = 1'b1;
            sw_d.pick_tag = ent_q.tag;
            sw_d.pick_ec  = ent_q.earliest;
            pick_d        = KI_C;
          end else if (FIRST || (ent_q.earliest < sw_i.low_ec)) begin
            sw_d.low_tag = ent_q.tag;
            sw_d.low_ec  = ent_q.earliest;
            low_d        = KI_C;
          end
        end
      end else begin
        if (!occ || (FIRST ? beats_head : beats_key)) begin
          sw_d.found = 1'b1;
          pick_d     = KI_C;
        end
      end
    end
  end

  // Slot update in the shift cycle
  always_comb begin
    ent_d = ent_q;
    if (shift_i) begin
      if (cmd_i.deq == rpiq_pkg::MODE_DEQ) begin
        if ((K_C >= pos_ext) && (K1_C < count_i)) begin
          ent_d = right_i;
        end
      end else begin
        if (K_C == pos_ext) begin
          ent_d = cmd_i.item;
        end else if ((K_C > pos_ext) && (K_C <= count_i)) begin
          ent_d = left_i;
        end
      end
    end
  end

  // Sweep record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= '0;
    end else begin
      sw_q <= sw_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    pick_q <= pick_d;
    low_q  <= low_d;
  end

  assign entry_o = ent_q;
  assign sw_o    = sw_q;
  assign pick_o  = pick_q;
  assign low_o   = low_q;

endmodule

`default_nettype wire

### rtl/ready_priority_issue_queue_core.sv
// ----------------------------------------------------------------------------
// Ready priority issue queue core
// Sorted ready queue for list scheduling, built as a row of slot cells.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Signals                      Content
//  s_axis    in    tvalid tready tdata tuser    enqueue or dequeue command
//  m_axis    out   tvalid tready tdata tuser    one result per command
//  apb       in    psel penable pwrite paddr    heuristic register at 0x0
//
// Flow: for a command that inserts or removes an entry, a search record walks
// the row of cells one cell per cycle, then the slots shift in the shift
// state and the output register is loaded. An enqueue into a full queue or
// a dequeue from an empty one skips the search and the shift and goes
// straight to loading the output register. One command is in work at a time.
// Reset empties the queue and clears the heuristic; slot contents are left.
// A stalled result holds in the output register while the next command is
// taken; that command finishes and waits until the register is free.
//
`default_nettype none

module ready_priority_issue_queue_core #(
  parameter int DEPTH = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Command stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,   // tag[7:0] weight[23:8] latency[27:24]
                                      // earliest_cycle[43:28] current_cycle[59:44]
  input  wire  [0:0]  s_axis_tuser,   // mode[0]
  // Result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_tag[7:0] next_cycle[23:8] occupancy[30:24]
  output logic [1:0]  m_axis_tuser,   // valid_res[0] full_error[1]
  // Register port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [1:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  rpiq_pkg::state_e state_q, state_d;
  rpiq_pkg::cmd_t   cmd_q;
  rpiq_pkg::res_t   res_q;
  rpiq_pkg::sweep_t launch_rec;
  rpiq_pkg::sweep_t tail;
  rpiq_pkg::entry_t in_item;

  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] pos_q;
  logic             launch_q;
  logic             heur_q;
  logic             m_valid_q;
  logic [31:0]      m_data_q;
  logic [1:0]       m_user_q;

  logic             accept;
  logic             in_mode;
  logic             full;
  logic             empty;
  logic             quick;
  logic             tail_done;
  logic             out_free;
  logic             cfg_wr;
  logic [IDX_W-1:0] sel_idx;
  logic [7:0]       sel_tag;
  logic [15:0]      sel_ec;
  logic [15:0]      issue;
  logic [15:0]      next_cyc;
  logic [CNT_W+6:0] count_ext;
  logic [6:0]       occupancy;

  rpiq_pkg::entry_t ent   [DEPTH];
  rpiq_pkg::sweep_t sw_out[DEPTH];
  logic [IDX_W-1:0] pick_out[DEPTH];
  logic [IDX_W-1:0] low_out [DEPTH];
  logic [DEPTH-1:0] sw_act;

  // Input unpacking
  assign in_mode          = s_axis_tuser[0];
  assign in_item.tag      = s_axis_tdata[7:0];
  assign in_item.weight   = s_axis_tdata[23:8];
  assign in_item.latency  = s_axis_tdata[27:24];
  assign in_item.earliest = s_axis_tdata[43:28];

  assign s_axis_tready = (state_q == rpiq_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == DEPTH_C);
  assign empty         = (count_q == '0);
  assign quick         = ((in_mode == rpiq_pkg::MODE_ENQ) && full) ||
                         ((in_mode == rpiq_pkg::MODE_DEQ) && empty);
  assign out_free      = !m_valid_q || m_axis_tready;

  // Search record launched into cell 0
  always_comb begin
    launch_rec        = '0;
    launch_rec.active = launch_q;
  end

  // Row of slot cells
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    rpiq_pkg::entry_t left_w, right_w;
    rpiq_pkg::sweep_t sw_in_w;
    logic [IDX_W-1:0] pick_in_w, low_in_w;

    if (k == 0) begin : g_head
      assign left_w    = cmd_q.item;
      assign sw_in_w   = launch_rec;
      assign pick_in_w = '0;
      assign low_in_w  = '0;
    end else begin : g_body
      assign left_w    = ent[k-1];
      assign sw_in_w   = sw_out[k-1];
      assign pick_in_w = pick_out[k-1];
      assign low_in_w  = low_out[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_w = ent[k];
    end else begin : g_mid
      assign right_w = ent[k+1];
    end

    rpiq_cell #(
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd_q),
      .count_i (count_q),
      .pos_i   (pos_q),
      .shift_i (state_q == rpiq_pkg::ST_SHIFT),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (ent[k]),
      .sw_i    (sw_in_w),
      .pick_i  (pick_in_w),
      .low_i   (low_in_w),
      .sw_o    (sw_out[k]),
      .pick_o  (pick_out[k]),
      .low_o   (low_out[k])
    );

    assign sw_act[k] = sw_out[k].active;
  end

  // Search outcome at the tail of the row
  assign tail      = sw_out[DEPTH-1];
  assign tail_done = (state_q == rpiq_pkg::ST_SWEEP) && tail.active;
  assign sel_idx   = tail.found ? pick_out[DEPTH-1] : low_out[DEPTH-1];
  assign sel_tag   = tail.found ? tail.pick_tag : tail.low_tag;
  assign sel_ec    = tail.found ? tail.pick_ec : tail.low_ec;
  assign issue     = (cmd_q.cur > sel_ec) ? cmd_q.cur : sel_ec;
  assign next_cyc  = (issue == rpiq_pkg::CYCLE_MAX) ? rpiq_pkg::CYCLE_MAX
                                                    : issue + 16'd1;

  assign count_ext = {7'b0, count_q};
  assign occupancy = count_ext[6:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rpiq_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = quick ? rpiq_pkg::ST_DONE : rpiq_pkg::ST_SWEEP;
        end
      end
      rpiq_pkg::ST_SWEEP: begin
        if (tail_done) begin
          state_d = rpiq_pkg::ST_SHIFT;
        end
      end
      rpiq_pkg::ST_SHIFT: begin
        state_d = rpiq_pkg::ST_DONE;
      end
      rpiq_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = rpiq_pkg::ST_IDLE;
        end
      end
      default: state_d = rpiq_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rpiq_pkg::ST_IDLE;
      count_q   <= '0;
      launch_q  <= 1'b0;
      m_valid_q <= 1'b0;
      heur_q    <= rpiq_pkg::HEUR_WEIGHT;
    end else begin
      state_q  <= state_d;
      launch_q <= accept && !quick;
      if (state_q == rpiq_pkg::ST_SHIFT) begin
        count_q <= (cmd_q.deq == rpiq_pkg::MODE_DEQ) ? count_q - CNT_W'(1)
                                                     : count_q + CNT_W'(1);
      end
      if ((state_q == rpiq_pkg::ST_DONE) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        heur_q <= pwdata[0];
      end
    end
  end

  // Command, result and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.deq  <= in_mode;
      cmd_q.heur <= heur_q;
      cmd_q.item <= in_item;
      cmd_q.cur  <= s_axis_tdata[59:44];
      // only full_error can be set on a quick command
      res_q      <= {1'b0, 8'd0, 16'd0, (in_mode == rpiq_pkg::MODE_ENQ) && full};
    end else if (tail_done) begin
      pos_q <= sel_idx;
      if (cmd_q.deq == rpiq_pkg::MODE_DEQ) begin
        res_q <= {1'b1, sel_tag, next_cyc, 1'b0};
      end else begin
        res_q <= '0;
      end
    end
    if ((state_q == rpiq_pkg::ST_DONE) && out_free) begin
      m_data_q <= {1'b0, occupancy, res_q.next_cycle, res_q.out_tag};
      m_user_q <= {res_q.full_error, res_q.valid_res};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == rpiq_pkg::REG_HEUR_ADDR);
  assign prdata = (paddr == rpiq_pkg::REG_HEUR_ADDR) ? {31'b0, heur_q} : 32'b0;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("entry count above depth");

  a_one_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(sw_act))
    else $error("more than one search record in the row");

  a_enq_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_done && (cmd_q.deq == rpiq_pkg::MODE_ENQ)) |-> tail.found)
    else $error("insert search ended without a slot");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == rpiq_pkg::ST_SHIFT) && (cmd_q.deq == rpiq_pkg::MODE_ENQ)) |=>
      (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the queue");

  a_res_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("result flags both set");

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Ready priority issue queue testbench
// Drives enqueue and dequeue commands into the core over the command stream,
// predicts each result with a scoreboard model of the sorted queue, and
// compares every result transfer field by field. Both sides idle at random
// while the heuristic register is switched between phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH     = 64;
  localparam int LIMIT     = 500000;
  localparam int LONG_HOLD = 400;

  // One command as the scheduler issues it
  typedef struct packed {
    logic        mode;
    logic [7:0]  tag;
    logic [15:0] weight;
    logic [3:0]  latency;
    logic [15:0] earliest;
    logic [15:0] current;
  } sched_cmd_t;

  // One result as the core reports it
  typedef struct packed {
    logic        valid_res;
    logic [7:0]  out_tag;
    logic [15:0] next_cycle;
    logic        full_error;
    logic [6:0]  occupancy;
  } issue_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [31:0] m_axis_tdata;
  wire  [1:0]  m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  // Scoreboard copy of the queue and its register
  rpiq_pkg::entry_t rq_mem [DEPTH];
  int          rq_count = 0;
  logic        rq_heur = rpiq_pkg::HEUR_WEIGHT;

  sched_cmd_t  sched_cmds[$];        // commands not yet on the bus
  issue_res_t  issue_results_due[$]; // predicted results, oldest first
  sched_cmd_t  cmd_on_bus;

  int          err_count = 0;
  int          cycle_count = 0;
  int          idle_pct = 25;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          hold_arm = 1'b0;
  bit          hold_done = 1'b0;
  logic [15:0] cyc_base = '0;

  ready_priority_issue_queue_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk_i = ~clk_i;

  // Apply one command to the scoreboard queue and return its result
  function automatic issue_res_t predict_issue(sched_cmd_t c);
    issue_res_t  r;
    int          pos;
    int          k;
    int          pick;
    int          low;
    bit          front;
    bit          found;
    logic [15:0] key_new;
    logic [15:0] key_old;
    logic [15:0] issue;
    r = '0;
    if (c.mode == rpiq_pkg::MODE_ENQ) begin
      if (rq_count >= DEPTH) begin
        r.full_error = 1'b1;
      end else begin
        pos = 0;
        key_new = (rq_heur == rpiq_pkg::HEUR_LATENCY) ? {12'b0, c.latency} : c.weight;
        if (rq_count > 0) begin
          // head compare: latency breaks a weight tie only here
          if (rq_heur == rpiq_pkg::HEUR_LATENCY)
            front = c.latency > rq_mem[0].latency;
          else
            front = (c.weight > rq_mem[0].weight) ||
                    (c.weight == rq_mem[0].weight && c.latency > rq_mem[0].latency);
          if (!front) begin
            pos = 1;
            key_old = (rq_heur == rpiq_pkg::HEUR_LATENCY) ? {12'b0, rq_mem[pos].latency}
                                                          : rq_mem[pos].weight;
            while (pos < rq_count && key_new <= key_old) begin
              pos++;
              if (pos < rq_count)
                key_old = (rq_heur == rpiq_pkg::HEUR_LATENCY)
                          ? {12'b0, rq_mem[pos].latency} : rq_mem[pos].weight;
            end
          end
        end
        for (k = rq_count; k > pos; k--)
          rq_mem[k] = rq_mem[k - 1];
        rq_mem[pos] = {c.tag, c.weight, c.latency, c.earliest};
        rq_count++;
      end
    end else if (rq_count > 0) begin
      // first ready entry in order, else first with the smallest earliest
      pick  = 0;
      low   = 0;
      found = 1'b0;
      for (k = 0; k < rq_count && !found; k++) begin
        if (rq_mem[k].earliest <= c.current) begin
          pick  = k;
          found = 1'b1;
        end else if (rq_mem[k].earliest < rq_mem[low].earliest) begin
          low = k;
        end
      end
      if (!found)
        pick = low;
      issue = (c.current > rq_mem[pick].earliest) ? c.current : rq_mem[pick].earliest;
      r.next_cycle = (issue == rpiq_pkg::CYCLE_MAX) ? rpiq_pkg::CYCLE_MAX : issue + 16'd1;
      r.out_tag    = rq_mem[pick].tag;
      r.valid_res  = 1'b1;
      for (k = pick; k + 1 < rq_count; k++)
        rq_mem[k] = rq_mem[k + 1];
      rq_count--;
    end
    r.occupancy = rq_count[6:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  // Random command around the current cycle window
  function automatic sched_cmd_t rand_cmd(int enq_pct);
    sched_cmd_t c;
    int         sel;
    c.mode     = ($urandom_range(0, 99) < enq_pct) ? rpiq_pkg::MODE_ENQ : rpiq_pkg::MODE_DEQ;
    c.tag      = 8'($urandom_range(0, 255));
    c.weight   = 16'($urandom_range(0, 65535));
    c.latency  = 4'($urandom_range(0, 15));
    c.earliest = 16'($urandom_range(0, 65535));
    c.current  = 16'($urandom_range(0, 65535));
    // narrow weights so that ties are common
    sel = $urandom_range(0, 9);
    if (sel < 5)
      c.weight = 16'($urandom_range(0, 3));
    else if (sel == 5)
      c.weight = 16'hFFFF;
    else if (sel == 6)
      c.weight = 16'h0000;
    sel = $urandom_range(0, 9);
    if (sel < 7)
      c.earliest = cyc_base + 16'($urandom_range(0, 48));
    else if (sel == 7)
      c.earliest = 16'hFFFF;
    else if (sel == 8)
      c.earliest = 16'h0000;
    sel = $urandom_range(0, 9);
    if (sel < 7)
      c.current = cyc_base + 16'($urandom_range(0, 60));
    else if (sel == 7)
      c.current = 16'hFFFF;
    else if (sel == 8)
      c.current = 16'h0000;
    return c;
  endfunction

  function automatic void add_enq(logic [7:0] tag, logic [15:0] w, logic [3:0] lat,
                                  logic [15:0] ec);
    sched_cmd_t c;
    c = rand_cmd(0);
    c.mode     = rpiq_pkg::MODE_ENQ;
    c.tag      = tag;
    c.weight   = w;
    c.latency  = lat;
    c.earliest = ec;
    sched_cmds.push_back(c);
  endfunction

  function automatic void add_deq(logic [15:0] cur);
    sched_cmd_t c;
    c = rand_cmd(0);
    c.mode    = rpiq_pkg::MODE_DEQ;
    c.current = cur;
    sched_cmds.push_back(c);
  endfunction

  // Heuristic register write: setup cycle, then access cycle
  task automatic apb_write(input logic heur);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= rpiq_pkg::REG_HEUR_ADDR;
    pwdata  <= {31'($urandom_range(0, 32'h7FFF_FFFF)), heur};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    rq_heur = heur;
  endtask

  task automatic wait_idle();
    while (sched_cmds.size() != 0 || s_axis_tvalid || issue_results_due.size() != 0)
      @(negedge clk_i);
  endtask

  // Command driver: one transfer per handshake, random gaps between
  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        issue_results_due.push_back(predict_issue(cmd_on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (sched_cmds.size() != 0) begin
          cmd_on_bus = sched_cmds.pop_front();
          s_axis_tdata  <= {4'b0, cmd_on_bus.current, cmd_on_bus.earliest,
                            cmd_on_bus.latency, cmd_on_bus.weight, cmd_on_bus.tag};
          s_axis_tuser  <= cmd_on_bus.mode;
          s_axis_tvalid <= 1'b1;
          if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            gap_left = $urandom_range(1, 8);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer, stall at random, one long hold
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    issue_res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (issue_results_due.size() == 0) begin
          $error("result transfer with no command outstanding");
          err_count++;
        end else begin
          want = issue_results_due.pop_front();
          check_field("valid_res", 16'(want.valid_res), 16'(m_axis_tuser[0]));
          check_field("out_tag", 16'(want.out_tag), 16'(m_axis_tdata[7:0]));
          check_field("next_cycle", want.next_cycle, m_axis_tdata[23:8]);
          check_field("full_error", 16'(want.full_error), 16'(m_axis_tuser[1]));
          check_field("occupancy", 16'(want.occupancy), 16'(m_axis_tdata[30:24]));
        end
      end
      if (hold_arm && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
          stall_left = $urandom_range(1, 8);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int enq_mix [12];
    int ph;
    int n;
    logic heur;
    enq_mix = '{55, 75, 40, 60, 65, 50, 70, 55, 60, 35, 80, 50};
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, weight order: empty dequeues, extremes, head tie rules
    apb_write(rpiq_pkg::HEUR_WEIGHT);
    add_deq(16'h0000);
    add_deq(16'hFFFF);
    add_enq(8'h11, 16'd100, 4'd3, 16'd10);
    add_enq(8'h22, 16'd100, 4'd5, 16'd20);     // equal weight, longer latency: front
    add_enq(8'h33, 16'd100, 4'd5, 16'd5);      // equal to head: goes behind equals
    add_enq(8'hFF, 16'hFFFF, 4'hF, 16'hFFFF);
    add_enq(8'h00, 16'h0000, 4'h0, 16'h0000);
    add_enq(8'h44, 16'd50, 4'hF, 16'd30);
    add_deq(16'd4);                            // ready entry at the tail
    add_deq(16'd0);                            // nothing ready: smallest earliest
    add_deq(16'hFFFF);                         // next cycle saturates
    add_deq(16'd25);
    add_enq(8'h55, 16'd50, 4'd0, 16'hFFFE);
    add_enq(8'h66, 16'd50, 4'hF, 16'd1);       // latency ignored past the head
    add_deq(16'hFFFE);
    add_deq(16'd0);
    wait_idle();

    // Directed, latency order
    apb_write(rpiq_pkg::HEUR_LATENCY);
    add_enq(8'h77, 16'h0000, 4'd7, 16'd3);
    add_enq(8'h88, 16'hFFFF, 4'd7, 16'd3);
    add_enq(8'h99, 16'd9, 4'hF, 16'd3);
    add_deq(16'd2);                            // equal smallest earliest: first wins
    add_deq(16'd3);
    for (n = 0; n < 5; n++)
      add_deq(16'hFFFF);
    wait_idle();

    // Random phases
    for (ph = 0; ph < 12; ph++) begin
      wait_idle();
      heur = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
      if (ph == 3) heur = rpiq_pkg::HEUR_WEIGHT;
      if (ph == 8) heur = rpiq_pkg::HEUR_LATENCY;
      apb_write(heur);
      cyc_base = (ph == 7) ? 16'hFFC0 : 16'($urandom_range(0, 65535));
      idle_pct = (ph % 3 == 2) ? 0 : 25;
      if (ph == 11)
        idle_pct = 0;
      if (ph == 4)
        hold_arm = 1'b1;
      if (ph == 3 || ph == 8) begin
        // fill past full, then mix
        n = DEPTH - rq_count + 3;
        repeat (n) begin
          sched_cmds.push_back(rand_cmd(100));
        end
        repeat (20) sched_cmds.push_back(rand_cmd(40));
      end else if (ph == 5) begin
        n = rq_count + 3;
        repeat (n) sched_cmds.push_back(rand_cmd(0));
      end else begin
        repeat (60) sched_cmds.push_back(rand_cmd(enq_mix[ph]));
      end
    end

    wait_idle();
    repeat (DEPTH + 8) @(posedge clk_i);
    if (err_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
